FILE: rtl/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants of the two-button press classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

	localparam int unsigned CFG_WIDTH = 16;

	localparam logic [CFG_WIDTH-1:0] SETTLE_RESET = 16'd30;
	localparam logic [CFG_WIDTH-1:0] LONG_RESET   = 16'd1000;

	typedef enum logic [0:0] {
		REG_SETTLE = 1'b0,
		REG_LONG   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		REL_NONE  = 2'd0,
		REL_SHORT = 2'd1,
		REL_LONG  = 2'd2
	} release_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_FIRST_SHORT  = 3'd1,
		EV_FIRST_LONG   = 3'd2,
		EV_SECOND_SHORT = 3'd3,
		EV_SECOND_LONG  = 3'd4,
		EV_COMBO        = 3'd5
	} event_t;

	typedef struct packed {
		logic update;
		logic clear_stable;
	} btn_ctl_t;

endpackage

FILE: rtl/tbpc_debounce.sv
// ----------------------------------------------------------------------------
// tbpc_debounce
// Debounce state of one button and its short/long release decision.
// ----------------------------------------------------------------------------
module tbpc_debounce #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tbpc_pkg::btn_ctl_t                 ctl,
	input  logic                               level,
	input  logic [TIME_WIDTH-1:0]              now,
	input  logic [tbpc_pkg::CFG_WIDTH-1:0]     settle_time,
	input  logic [tbpc_pkg::CFG_WIDTH-1:0]     long_time,
	output tbpc_pkg::release_t                 rel
);

	logic                  stable_q;
	logic                  last_q;
	logic [TIME_WIDTH-1:0] change_q;
	logic [TIME_WIDTH-1:0] press_q;

	logic                  stable_d;
	logic [TIME_WIDTH-1:0] change_d;
	logic [TIME_WIDTH-1:0] press_d;
	logic [TIME_WIDTH-1:0] settle_age;
	logic [TIME_WIDTH-1:0] hold_age;
	logic                  settled;

	always_comb begin
		change_d   = (level != last_q) ? now : change_q;
		settle_age = now - change_d;
		hold_age   = now - press_q;
		settled    = settle_age >= TIME_WIDTH'(settle_time);
		stable_d   = stable_q;
		press_d    = press_q;
		rel        = tbpc_pkg::REL_NONE;
		if (settled) begin
			if (level && !stable_q) begin
				stable_d = 1'b1;
				press_d  = now;
			end else if (!level && stable_q) begin
				stable_d = 1'b0;
				rel = (hold_age >= TIME_WIDTH'(long_time)) ?
					tbpc_pkg::REL_LONG : tbpc_pkg::REL_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			last_q   <= 1'b0;
			change_q <= '0;
			press_q  <= '0;
		end else if (ctl.clear_stable) begin
			stable_q <= 1'b0;
		end else if (ctl.update) begin
			stable_q <= stable_d;
			last_q   <= level;
			change_q <= change_d;
			press_q  <= press_d;
		end
	end

endmodule

FILE: rtl/two_button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier_unit
// Debounces two buttons per poll beat and classifies short, long and combo.
// ----------------------------------------------------------------------------
// One poll beat is accepted every clock cycle while in_stall is low. A beat
// is captured in an input register, classified against the debounce state
// while it sits there and its event is held in the result register. The
// debounce state is updated in the same cycle the event is formed, which lets
// consecutive beats follow each other without a gap. Input stall rises only
// when both the input register and the result register are full and the
// output is stalled.
module two_button_press_classifier_unit #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           first_down,
	input  logic                           second_down,
	input  logic [31:0]                    now_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     event_res,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [tbpc_pkg::CFG_WIDTH-1:0] cfg_data
);

	logic [tbpc_pkg::CFG_WIDTH-1:0] settle_q;
	logic [tbpc_pkg::CFG_WIDTH-1:0] long_q;

	logic                  valid_s1;
	logic                  first_s1;
	logic                  second_s1;
	logic [TIME_WIDTH-1:0] now_s1;

	logic                 out_valid_q;
	tbpc_pkg::event_t     event_q;
	logic                 combo_latched_q;
	logic                 combo_consumed_q;

	logic                 advance;
	logic                 fire;
	tbpc_pkg::btn_ctl_t   first_ctl;
	tbpc_pkg::btn_ctl_t   second_ctl;
	tbpc_pkg::release_t   first_rel;
	tbpc_pkg::release_t   second_rel;
	tbpc_pkg::event_t     event_d;
	logic                 latched_d;
	logic                 consumed_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= tbpc_pkg::SETTLE_RESET;
			long_q   <= tbpc_pkg::LONG_RESET;
		end else if (cfg_we) begin
			case (tbpc_pkg::reg_idx_t'(cfg_index))
				tbpc_pkg::REG_SETTLE: settle_q <= cfg_data;
				tbpc_pkg::REG_LONG:   long_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			first_s1  <= first_down;
			second_s1 <= second_down;
			now_s1    <= TIME_WIDTH'(now_ms);
		end
	end

	tbpc_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_first (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (first_ctl),
		.level       (first_s1),
		.now         (now_s1),
		.settle_time (settle_q),
		.long_time   (long_q),
		.rel         (first_rel)
	);

	tbpc_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_second (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (second_ctl),
		.level       (second_s1),
		.now         (now_s1),
		.settle_time (settle_q),
		.long_time   (long_q),
		.rel         (second_rel)
	);

	// classification
	always_comb begin
		first_ctl  = '0;
		second_ctl = '0;
		event_d    = tbpc_pkg::EV_NONE;
		latched_d  = combo_latched_q;
		consumed_d = combo_consumed_q;
		if (first_s1 && second_s1) begin
			if (!combo_latched_q) begin
				latched_d               = 1'b1;
				consumed_d              = 1'b1;
				first_ctl.clear_stable  = fire;
				second_ctl.clear_stable = fire;
				event_d                 = tbpc_pkg::EV_COMBO;
			end
		end else begin
			if (!first_s1 && !second_s1) begin
				latched_d  = 1'b0;
				consumed_d = 1'b0;
			end
			first_ctl.update = fire;
			if (consumed_d) begin
				second_ctl.update = fire;
			end else begin
				case (first_rel)
					tbpc_pkg::REL_SHORT: event_d = tbpc_pkg::EV_FIRST_SHORT;
					tbpc_pkg::REL_LONG:  event_d = tbpc_pkg::EV_FIRST_LONG;
					default: begin
						second_ctl.update = fire;
						case (second_rel)
							tbpc_pkg::REL_SHORT: event_d = tbpc_pkg::EV_SECOND_SHORT;
							tbpc_pkg::REL_LONG:  event_d = tbpc_pkg::EV_SECOND_LONG;
							default:             event_d = tbpc_pkg::EV_NONE;
						endcase
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combo_latched_q  <= 1'b0;
			combo_consumed_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (fire) begin
				combo_latched_q  <= latched_d;
				combo_consumed_q <= consumed_d;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			event_q <= event_d;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

	a_consumed_implies_latched: assert property (@(posedge clk) disable iff (!arst_n)
		combo_consumed_q |-> combo_latched_q)
		else $error("combo consumed without latch");

	a_combo_latches: assert property (@(posedge clk) disable iff (!arst_n)
		fire && first_s1 && second_s1 && !combo_latched_q |=>
			combo_latched_q && out_valid && event_res == tbpc_pkg::EV_COMBO)
		else $error("combo beat did not latch");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room downstream");

	a_taken_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s1 |=> !out_valid)
		else $error("result repeated after being taken");

endmodule

FILE: bench/two_button_press_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_press_classifier_unit_tb
// Drives poll beats into the two-button classifier and checks each event.
// ----------------------------------------------------------------------------
// A directed table covers reset behavior, short, long and combo events, the
// priority of the first button and timestamp wrap. Random phases follow under
// several register settings, with zero and full-scale values among them. Every
// accepted poll beat is run through a behavioral classifier in the bench and
// the expected event is queued; each result beat is compared in order. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module two_button_press_classifier_unit_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED     = 26;
	localparam int N_PHASES       = 7;
	localparam int PHASE_POLLS    = 280;

	typedef struct {
		bit        stable;
		bit        level;
		bit [31:0] changed_at;
		bit [31:0] pressed_at;
	} btn_track_t;

	typedef struct packed {
		logic             a;
		logic             b;
		logic [31:0]      now;
		logic             typed;
		tbpc_pkg::event_t ev;
	} poll_row_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic                           first_down  = 1'b0;
	logic                           second_down = 1'b0;
	logic [31:0]                    now_ms      = '0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic [2:0]                     event_res;
	logic                           cfg_we      = 1'b0;
	logic [0:0]                     cfg_index   = tbpc_pkg::REG_SETTLE;
	logic [tbpc_pkg::CFG_WIDTH-1:0] cfg_data    = '0;

	// expectation typed into the directed table, sent along with the beat
	logic             typed_row = 1'b0;
	tbpc_pkg::event_t typed_ev  = tbpc_pkg::EV_NONE;

	btn_track_t       first_key;
	btn_track_t       second_key;
	bit               combo_held;
	bit               combo_spent;
	bit [15:0]        settle_ms;
	bit [15:0]        long_ms;
	tbpc_pkg::event_t pending_events [$];
	tbpc_pkg::event_t predicted;
	tbpc_pkg::event_t got_ev;
	int               mismatches;
	int               polls_sent;
	int               results_seen;
	int               ev_seen [0:7];
	int               settings_used;
	int               quiet_cycles;
	bit               calm;
	bit               lvl_a;
	bit               lvl_b;
	bit [31:0]        clock_ms;

	poll_row_t dir_rows [0:N_DIRECTED-1] = '{
		'{1'b0, 1'b0, 32'd0,          1'b1, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b0, 32'd100,        1'b1, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b0, 32'd130,        1'b1, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd200,        1'b1, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd230,        1'b1, tbpc_pkg::EV_FIRST_SHORT},
		'{1'b1, 1'b0, 32'd300,        1'b0, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b0, 32'd330,        1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd1400,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd1430,       1'b1, tbpc_pkg::EV_FIRST_LONG},
		'{1'b0, 1'b1, 32'd2000,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'd2030,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd2100,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd2130,       1'b1, tbpc_pkg::EV_SECOND_SHORT},
		'{1'b0, 1'b1, 32'd3000,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'd3030,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b1, 32'd3040,       1'b1, tbpc_pkg::EV_COMBO},
		'{1'b1, 1'b1, 32'd3041,       1'b1, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'd3100,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'd3200,       1'b0, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b0, 32'hFFFF_FFF0,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b1, 1'b0, 32'h0000_000E,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'h0000_0100,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'h0000_0400,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b1, 32'h0000_0420,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, tbpc_pkg::EV_NONE},
		'{1'b0, 1'b0, 32'h0000_0000,  1'b0, tbpc_pkg::EV_NONE}
	};

	two_button_press_classifier_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_down  (first_down),
		.second_down (second_down),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic tbpc_pkg::release_t settle_key(inout btn_track_t k, input bit lvl,
			input bit [31:0] now);
		bit [31:0] held;
		if (lvl != k.level) begin
			k.changed_at = now;
			k.level      = lvl;
		end
		held = now - k.changed_at;
		if (held < {16'd0, settle_ms})
			return tbpc_pkg::REL_NONE;
		if (lvl && !k.stable) begin
			k.stable     = 1'b1;
			k.pressed_at = now;
			return tbpc_pkg::REL_NONE;
		end
		if (!lvl && k.stable) begin
			k.stable = 1'b0;
			held     = now - k.pressed_at;
			return (held >= {16'd0, long_ms}) ? tbpc_pkg::REL_LONG : tbpc_pkg::REL_SHORT;
		end
		return tbpc_pkg::REL_NONE;
	endfunction

	function automatic tbpc_pkg::event_t classify_poll(bit a, bit b, bit [31:0] now);
		tbpc_pkg::event_t   ev;
		tbpc_pkg::release_t r;
		ev = tbpc_pkg::EV_NONE;
		if (a && b) begin
			if (!combo_held) begin
				combo_held        = 1'b1;
				combo_spent       = 1'b1;
				first_key.stable  = 1'b0;
				second_key.stable = 1'b0;
				ev                = tbpc_pkg::EV_COMBO;
			end
		end else begin
			if (!a && !b) begin
				combo_held  = 1'b0;
				combo_spent = 1'b0;
			end
			if (combo_spent) begin
				r = settle_key(first_key, a, now);
				r = settle_key(second_key, b, now);
			end else begin
				r = settle_key(first_key, a, now);
				if (r == tbpc_pkg::REL_SHORT)
					ev = tbpc_pkg::EV_FIRST_SHORT;
				else if (r == tbpc_pkg::REL_LONG)
					ev = tbpc_pkg::EV_FIRST_LONG;
				else begin
					r = settle_key(second_key, b, now);
					if (r == tbpc_pkg::REL_SHORT)
						ev = tbpc_pkg::EV_SECOND_SHORT;
					else if (r == tbpc_pkg::REL_LONG)
						ev = tbpc_pkg::EV_SECOND_LONG;
				end
			end
		end
		return ev;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// poll beat accepted: predict its event
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predicted = classify_poll(first_down, second_down, now_ms);
			pending_events.push_back(typed_row ? typed_ev : predicted);
			polls_sent++;
		end
	end

	// result beat accepted: compare with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (event_res <= 3'd7 && !$isunknown(event_res))
				ev_seen[event_res]++;
			if (pending_events.size() == 0)
				report_mismatch("unexpected event_res", event_res, -1);
			else begin
				got_ev = pending_events.pop_front();
				if (event_res !== got_ev)
					report_mismatch("event_res", event_res, got_ev);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d events outstanding",
				WATCHDOG_LIMIT, pending_events.size());
			$display("two_button_press_classifier_unit_tb failed");
			$finish;
		end
	end

	// receiver side
	initial begin
		int n;
		forever begin
			@(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic send_poll(bit a, bit b, bit [31:0] now, bit typed, tbpc_pkg::event_t ev);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid    <= 1'b1;
		first_down  <= a;
		second_down <= b;
		now_ms      <= now;
		typed_row   <= typed;
		typed_ev    <= ev;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(tbpc_pkg::reg_idx_t idx, bit [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tbpc_pkg::REG_SETTLE)
			settle_ms = value;
		else
			long_ms = value;
	endtask

	task automatic random_polls(int count);
		int        r;
		bit [31:0] d;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				lvl_a = 1'($urandom_range(0, 1));
				lvl_b = 1'($urandom_range(0, 1));
			end else begin
				if ($urandom_range(0, 99) < 12)
					lvl_a = !lvl_a;
				if ($urandom_range(0, 99) < 12)
					lvl_b = !lvl_b;
			end
			r = $urandom_range(0, 99);
			if (r < 55)
				d = $urandom_range(0, settle_ms / 2 + 2);
			else if (r < 85)
				d = $urandom_range(0, long_ms / 2 + 2);
			else if (r < 97)
				d = $urandom_range(0, 3);
			else
				d = $urandom;
			clock_ms = clock_ms + d;
			send_poll(lvl_a, lvl_b, clock_ms, 1'b0, tbpc_pkg::EV_NONE);
			if (i == count / 2)
				drain();
		end
	endtask

	initial begin
		bit [15:0] ph_settle;
		bit [15:0] ph_long;
		first_key     = '{1'b0, 1'b0, 32'd0, 32'd0};
		second_key    = first_key;
		combo_held    = 1'b0;
		combo_spent   = 1'b0;
		settle_ms     = tbpc_pkg::SETTLE_RESET;
		long_ms       = tbpc_pkg::LONG_RESET;
		mismatches    = 0;
		polls_sent    = 0;
		results_seen  = 0;
		settings_used = 1;
		calm          = 1'b0;
		lvl_a         = 1'b0;
		lvl_b         = 1'b0;
		clock_ms      = 32'd5000;
		for (int i = 0; i < 8; i++)
			ev_seen[i] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_poll(dir_rows[i].a, dir_rows[i].b, dir_rows[i].now,
				dir_rows[i].typed, dir_rows[i].ev);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin ph_settle = 16'd0;      ph_long = 16'd0;      end
				1: begin ph_settle = 16'hFFFF;   ph_long = 16'hFFFF;   end
				2: begin ph_settle = 16'd1;      ph_long = 16'd2;      end
				3: begin ph_settle = 16'd30;     ph_long = 16'd1000;   end
				4: begin ph_settle = 16'd5;      ph_long = 16'd40;     end
				5: begin
					ph_settle = 16'($urandom_range(0, 50));
					ph_long   = 16'($urandom_range(0, 400));
				end
				default: begin
					ph_settle = 16'($urandom);
					ph_long   = 16'($urandom);
				end
			endcase
			write_reg(tbpc_pkg::REG_SETTLE, ph_settle);
			write_reg(tbpc_pkg::REG_LONG, ph_long);
			settings_used++;
			calm = (p == 3 || p == 5);
			if (p == 0) begin
				// zero settle counts at once, zero threshold makes every release long
				send_poll(1'b0, 1'b0, 32'd4, 1'b0, tbpc_pkg::EV_NONE);
				send_poll(1'b1, 1'b0, 32'd5, 1'b1, tbpc_pkg::EV_NONE);
				send_poll(1'b0, 1'b0, 32'd5, 1'b1, tbpc_pkg::EV_FIRST_LONG);
				send_poll(1'b0, 1'b1, 32'd6, 1'b1, tbpc_pkg::EV_NONE);
				send_poll(1'b0, 1'b0, 32'd6, 1'b1, tbpc_pkg::EV_SECOND_LONG);
			end
			random_polls(PHASE_POLLS);
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d polls under %0d register settings, %0d events checked",
			polls_sent, settings_used, results_seen);
		$display("short %0d/%0d, long %0d/%0d, combo %0d (first/second)",
			ev_seen[tbpc_pkg::EV_FIRST_SHORT], ev_seen[tbpc_pkg::EV_SECOND_SHORT],
			ev_seen[tbpc_pkg::EV_FIRST_LONG], ev_seen[tbpc_pkg::EV_SECOND_LONG],
			ev_seen[tbpc_pkg::EV_COMBO]);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("two_button_press_classifier_unit_tb passed");
		else begin
			if (pending_events.size() != 0)
				report_mismatch("events never delivered", 0, pending_events.size());
			$display("two_button_press_classifier_unit_tb failed");
		end
		$finish;
	end

endmodule

FILE: two_button_press_classifier_unit.f
rtl/tbpc_pkg.sv
rtl/tbpc_debounce.sv
rtl/two_button_press_classifier_unit.sv
bench/two_button_press_classifier_unit_tb.sv
